// ===== rtl/tsg_pkg.sv =====
// Package for the turtle segment generator: widths, command codes, sine table
// and angle helpers. No dependencies; every other file imports it.
package tsg_pkg;

    localparam int POS_W     = 24;
    localparam int STEP_W    = 8;
    localparam int ANGLE_W   = 9;
    localparam int SYM_W     = 8;
    localparam int SIN_W     = 13;
    localparam int TRIG_FRAC = 12;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int SIN_IDX_W = 7;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [ANGLE_W-1:0]      angle_t;
    typedef logic [STEP_W-1:0]       step_t;
    typedef logic [SYM_W-1:0]        sym_t;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic RES_SEGMENT  = 1'b0;
    localparam logic RES_OVERFLOW = 1'b1;

    localparam sym_t SYM_FORWARD    = 8'h46;
    localparam sym_t SYM_TURN_PLUS  = 8'h2B;
    localparam sym_t SYM_TURN_MINUS = 8'h2D;
    localparam sym_t SYM_PUSH       = 8'h5B;
    localparam sym_t SYM_POP        = 8'h5D;

    typedef enum logic {
        REG_STEP_LENGTH = 1'b0,
        REG_TURN_ANGLE  = 1'b1
    } reg_idx_t;

    localparam step_t  STEP_LENGTH_RESET = 8'd10;
    localparam angle_t TURN_ANGLE_RESET  = 9'd90;
    localparam angle_t START_HEADING     = 9'd270;
    localparam angle_t QUARTER_TURN      = 9'd90;
    localparam angle_t HALF_TURN         = 9'd180;
    localparam logic [ANGLE_W:0] FULL_TURN = 10'd360;

    localparam logic [SIN_W-1:0] SINE_Q12 [91] = '{
        13'd0,    13'd71,   13'd143,  13'd214,  13'd286,
        13'd357,  13'd428,  13'd499,  13'd570,  13'd641,
        13'd711,  13'd782,  13'd852,  13'd921,  13'd991,
        13'd1060, 13'd1129, 13'd1198, 13'd1266, 13'd1334,
        13'd1401, 13'd1468, 13'd1534, 13'd1600, 13'd1666,
        13'd1731, 13'd1796, 13'd1860, 13'd1923, 13'd1986,
        13'd2048, 13'd2110, 13'd2171, 13'd2231, 13'd2290,
        13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578,
        13'd2633, 13'd2687, 13'd2741, 13'd2793, 13'd2845,
        13'd2896, 13'd2946, 13'd2996, 13'd3044, 13'd3091,
        13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314,
        13'd3355, 13'd3396, 13'd3435, 13'd3474, 13'd3511,
        13'd3547, 13'd3582, 13'd3617, 13'd3650, 13'd3681,
        13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824,
        13'd3849, 13'd3873, 13'd3896, 13'd3917, 13'd3937,
        13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021,
        13'd4034, 13'd4046, 13'd4056, 13'd4065, 13'd4074,
        13'd4080, 13'd4086, 13'd4090, 13'd4094, 13'd4095,
        13'd4096
    };

    typedef struct packed {
        logic             neg;
        logic [SIN_W-1:0] mag;
    } trig_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stk_stat_t;

    typedef struct packed {
        logic result_kind;
        pos_t start_x;
        pos_t start_y;
        pos_t end_x;
        pos_t end_y;
    } seg_item_t;

    // Both arguments in 0..359.
    function automatic angle_t add_angle(input angle_t a, input angle_t b);
        logic [ANGLE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= FULL_TURN)
            s = s - FULL_TURN;
        return s[ANGLE_W-1:0];
    endfunction

    function automatic angle_t sub_angle(input angle_t a, input angle_t b);
        logic [ANGLE_W:0] s;
        s = {1'b0, a} + FULL_TURN - {1'b0, b};
        if (s >= FULL_TURN)
            s = s - FULL_TURN;
        return s[ANGLE_W-1:0];
    endfunction

    // Any 9-bit value down to 0..359.
    function automatic angle_t wrap_angle(input angle_t a);
        logic [ANGLE_W:0] s;
        s = {1'b0, a};
        if (s >= FULL_TURN)
            s = s - FULL_TURN;
        return s[ANGLE_W-1:0];
    endfunction

    // Fold a heading in 0..359 onto the quarter-wave table.
    function automatic trig_t sine_of(input angle_t deg);
        angle_t d;
        trig_t  r;
        r.neg = (deg >= HALF_TURN);
        d = r.neg ? (deg - HALF_TURN) : deg;
        if (d > QUARTER_TURN)
            d = HALF_TURN - d;
        r.mag = SINE_Q12[d[SIN_IDX_W-1:0]];
        return r;
    endfunction

endpackage

// ===== rtl/tsg_if.sv =====
// Valid/ready channel interfaces for command items and segment results.
// Depends on tsg_pkg.
interface tsg_cmd_if;
    import tsg_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    sym_t symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface tsg_seg_if;
    import tsg_pkg::*;

    logic valid;
    logic ready;
    logic result_kind;
    pos_t start_x;
    pos_t start_y;
    pos_t end_x;
    pos_t end_y;

    modport source (output valid, output result_kind, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input result_kind, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

// ===== rtl/tsg_regs.sv =====
// APB-style configuration registers: step length and turn angle.
// Depends on tsg_pkg.
module tsg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [tsg_pkg::DATA_W-1:0] pwdata,
    output logic [tsg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tsg_pkg::step_t             step_length,
    output tsg_pkg::angle_t            turn_angle
);
    import tsg_pkg::*;

    step_t    step_reg;
    angle_t   turn_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LENGTH_RESET;
            turn_reg <= TURN_ANGLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_STEP_LENGTH: step_reg <= pwdata[STEP_W-1:0];
                REG_TURN_ANGLE:  turn_reg <= pwdata[ANGLE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STEP_LENGTH: prdata = DATA_W'(step_reg);
            REG_TURN_ANGLE:  prdata = DATA_W'(turn_reg);
            default:         prdata = '0;
        endcase
    end

    assign step_length = step_reg;
    assign turn_angle  = wrap_angle(turn_reg);

endmodule

// ===== rtl/tsg_disp.sv =====
// Per-axis displacement for one forward step: sine lookup, multiply, round.
// Depends on tsg_pkg.
module tsg_disp
#(
    parameter int POS_FRAC_BITS = 8
)
(
    input  tsg_pkg::angle_t heading,
    input  tsg_pkg::step_t  step_length,
    output tsg_pkg::pos_t   disp_x,
    output tsg_pkg::pos_t   disp_y
);
    import tsg_pkg::*;

    localparam int PROD_W  = STEP_W + SIN_W;
    localparam int ROUND_W = PROD_W + POS_FRAC_BITS + 1;
    localparam int HALF_LSB = 1 << (TRIG_FRAC - 1);

    angle_t             lane_deg [2];
    trig_t              lane_trig[2];
    logic [PROD_W-1:0]  lane_prod[2];
    logic [ROUND_W-1:0] lane_rnd [2];
    logic [POS_W-1:0]   lane_mag [2];
    pos_t               lane_disp[2];

    always_comb
    begin
        lane_deg[0] = add_angle(heading, QUARTER_TURN);
        lane_deg[1] = heading;
        for (int i = 0; i < 2; i++)
        begin
            lane_trig[i] = sine_of(lane_deg[i]);
            lane_prod[i] = PROD_W'(step_length) * PROD_W'(lane_trig[i].mag);
            lane_rnd[i]  = (ROUND_W'(lane_prod[i]) << POS_FRAC_BITS) + ROUND_W'(HALF_LSB);
            lane_mag[i]  = POS_W'(lane_rnd[i] >> TRIG_FRAC);
            lane_disp[i] = lane_trig[i].neg ? pos_t'(-lane_mag[i]) : pos_t'(lane_mag[i]);
        end
    end

    assign disp_x = lane_disp[0];
    assign disp_y = lane_disp[1];

endmodule

// ===== rtl/tsg_stack.sv =====
// Position stack: top entry in a register, older entries in a memory with
// a registered read of the entry below the top. Depends on tsg_pkg.
module tsg_stack
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsg_pkg::stk_ctrl_t   ctrl,
    input  tsg_pkg::pos_t        push_x,
    input  tsg_pkg::pos_t        push_y,
    output tsg_pkg::pos_t        top_x,
    output tsg_pkg::pos_t        top_y,
    output tsg_pkg::stk_stat_t   stat
);
    import tsg_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int EW = 2 * POS_W;

    logic [EW-1:0] mem [STACK_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [EW-1:0] top_reg;
    logic [EW-1:0] top_next;
    logic [EW-1:0] below_reg;
    logic [CW-1:0] wr_pos;
    logic [CW-1:0] rd_pos;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(STACK_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        priority if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push && !stat.full)
        begin
            count_next = count_reg + CW'(1);
            top_next   = {push_x, push_y};
            wr_en      = !stat.empty;
        end
        else if (ctrl.pop && !stat.empty)
        begin
            count_next = count_reg - CW'(1);
            top_next   = below_reg;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign wr_pos  = count_reg - CW'(1);
    assign rd_pos  = count_next - CW'(2);
    assign wr_addr = wr_pos[AW-1:0];
    assign rd_addr = rd_pos[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= top_reg;
        below_reg <= (wr_en && (wr_addr == rd_addr)) ? top_reg : mem[rd_addr];
        top_reg   <= top_next;
    end

    assign top_x = top_reg[EW-1:POS_W];
    assign top_y = top_reg[POS_W-1:0];

endmodule

// ===== rtl/turtle_segment_generator.sv =====
// Turtle segment generator: returns a result for a forward step or a push onto
// a full stack through the command and output registers. It takes one command
// transaction per clock, set by the update of heading, position and the stack
// top register, which each command reads and writes before the next may follow;
// only a command that gives a result waits, while the previous result in the
// output register is unread; other commands keep flowing meanwhile.
// Depends on tsg_pkg, tsg_if, tsg_regs, tsg_disp and tsg_stack.
module turtle_segment_generator
#(
    parameter int STACK_DEPTH   = 16,
    parameter int POS_FRAC_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    tsg_cmd_if.sink                    cmd,
    tsg_seg_if.source                  seg,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [tsg_pkg::DATA_W-1:0] pwdata,
    output logic [tsg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import tsg_pkg::*;

    step_t     step_length;
    angle_t    turn_angle;
    pos_t      disp_x;
    pos_t      disp_y;
    pos_t      top_x;
    pos_t      top_y;
    stk_ctrl_t stk_ctrl;
    stk_stat_t stk_stat;

    logic      s1_valid_reg;
    logic      s1_kind_reg;
    sym_t      s1_symbol_reg;

    pos_t      pos_x_reg;
    pos_t      pos_x_next;
    pos_t      pos_y_reg;
    pos_t      pos_y_next;
    angle_t    heading_reg;
    angle_t    heading_next;

    logic      out_valid_reg;
    seg_item_t out_item_reg;
    seg_item_t out_item_next;

    logic      is_cmd;
    logic      is_forward;
    logic      is_push;
    logic      is_pop;
    logic      has_result;
    logic      out_free;
    logic      advance;
    pos_t      end_x;
    pos_t      end_y;

    tsg_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .step_length (step_length),
        .turn_angle  (turn_angle)
    );

    tsg_disp #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_disp
    (
        .heading     (heading_reg),
        .step_length (step_length),
        .disp_x      (disp_x),
        .disp_y      (disp_y)
    );

    tsg_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (stk_ctrl),
        .push_x (pos_x_reg),
        .push_y (pos_y_reg),
        .top_x  (top_x),
        .top_y  (top_y),
        .stat   (stk_stat)
    );

    assign is_cmd     = s1_valid_reg && (s1_kind_reg == KIND_COMMAND);
    assign is_forward = is_cmd && (s1_symbol_reg == SYM_FORWARD);
    assign is_push    = is_cmd && (s1_symbol_reg == SYM_PUSH);
    assign is_pop     = is_cmd && (s1_symbol_reg == SYM_POP);
    assign has_result = is_forward || (is_push && stk_stat.full);
    assign out_free   = !out_valid_reg || seg.ready;
    assign advance    = s1_valid_reg && (!has_result || out_free);
    assign cmd.ready  = !s1_valid_reg || advance;

    assign stk_ctrl.clear = advance && (s1_kind_reg == KIND_RESTART);
    assign stk_ctrl.push  = advance && is_push;
    assign stk_ctrl.pop   = advance && is_pop;

    assign end_x = pos_x_reg + disp_x;
    assign end_y = pos_y_reg + disp_y;

    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        if (s1_kind_reg == KIND_RESTART)
        begin
            pos_x_next   = '0;
            pos_y_next   = '0;
            heading_next = START_HEADING;
        end
        else
        begin
            unique case (s1_symbol_reg)
                SYM_FORWARD:
                begin
                    pos_x_next = end_x;
                    pos_y_next = end_y;
                end
                SYM_TURN_PLUS:  heading_next = add_angle(heading_reg, turn_angle);
                SYM_TURN_MINUS: heading_next = sub_angle(heading_reg, turn_angle);
                SYM_POP:
                begin
                    if (!stk_stat.empty)
                    begin
                        pos_x_next = top_x;
                        pos_y_next = top_y;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (is_forward)
            out_item_next = '{RES_SEGMENT, pos_x_reg, pos_y_reg, end_x, end_y};
        else
            out_item_next = '{RES_OVERFLOW, '0, '0, '0, '0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= START_HEADING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                s1_valid_reg <= cmd.valid;
            if (advance)
            begin
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                heading_reg <= heading_next;
            end
            if (advance && has_result)
                out_valid_reg <= 1'b1;
            else if (seg.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_kind_reg   <= cmd.kind;
            s1_symbol_reg <= cmd.symbol;
        end
        if (advance && has_result)
            out_item_reg <= out_item_next;
    end

    assign seg.valid       = out_valid_reg;
    assign seg.result_kind = out_item_reg.result_kind;
    assign seg.start_x     = out_item_reg.start_x;
    assign seg.start_y     = out_item_reg.start_y;
    assign seg.end_x       = out_item_reg.end_x;
    assign seg.end_y       = out_item_reg.end_y;

endmodule

// ===== rtl/tsg_checker.sv =====
// Port-level checks for the turtle segment generator, bound to the top level.
// Depends on tsg_pkg and turtle_segment_generator.
module tsg_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          seg_valid,
    input logic          seg_ready,
    input logic          seg_result_kind,
    input tsg_pkg::pos_t seg_start_x,
    input tsg_pkg::pos_t seg_start_y,
    input tsg_pkg::pos_t seg_end_x,
    input tsg_pkg::pos_t seg_end_y
);
    import tsg_pkg::*;

    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid)
        else $error("segment transaction dropped while stalled");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && (seg_result_kind == RES_OVERFLOW) |->
            (seg_start_x == '0) && (seg_start_y == '0) &&
            (seg_end_x == '0) && (seg_end_y == '0))
        else $error("overflow transaction carries coordinates");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !seg_valid |-> cmd_ready)
        else $error("command stalled with empty output register");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seg_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("segment transaction without a command two cycles earlier");

endmodule

bind turtle_segment_generator tsg_checker u_tsg_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .seg_valid       (seg.valid),
    .seg_ready       (seg.ready),
    .seg_result_kind (seg.result_kind),
    .seg_start_x     (seg.start_x),
    .seg_start_y     (seg.start_y),
    .seg_end_x       (seg.end_x),
    .seg_end_y       (seg.end_y)
);

// ===== sim/turtle_segment_generator_tb.sv =====
// Self-checking testbench for turtle_segment_generator: random and directed command
// transactions, APB register writes and a scoreboard that predicts every segment.
// Depends on tsg_pkg, tsg_if and the RTL of the block.
module turtle_segment_generator_tb;
    import tsg_pkg::*;

    localparam int STACK_SLOTS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int HOLD_CYCLES = 400;

    localparam int QSIN_Q12 [91] = '{
           0,   71,  143,  214,  286,  357,  428,  499,  570,  641,
         711,  782,  852,  921,  991, 1060, 1129, 1198, 1266, 1334,
        1401, 1468, 1534, 1600, 1666, 1731, 1796, 1860, 1923, 1986,
        2048, 2110, 2171, 2231, 2290, 2349, 2408, 2465, 2522, 2578,
        2633, 2687, 2741, 2793, 2845, 2896, 2946, 2996, 3044, 3091,
        3138, 3183, 3228, 3271, 3314, 3355, 3396, 3435, 3474, 3511,
        3547, 3582, 3617, 3650, 3681, 3712, 3742, 3770, 3798, 3824,
        3849, 3873, 3896, 3917, 3937, 3956, 3974, 3991, 4006, 4021,
        4034, 4046, 4056, 4065, 4074, 4080, 4086, 4090, 4094, 4095,
        4096
    };

    typedef struct packed {
        logic kind;
        sym_t symbol;
    } cmd_item_t;

    class segment_predictor;
        step_t     step_len;
        angle_t    turn;
        pos_t      px;
        pos_t      py;
        angle_t    hdg;
        pos_t      saved_px [STACK_SLOTS];
        pos_t      saved_py [STACK_SLOTS];
        int        depth;
        seg_item_t pending_segs [$];
        int        fail_count;

        function new();
            step_len   = STEP_LENGTH_RESET;
            turn       = TURN_ANGLE_RESET;
            px         = '0;
            py         = '0;
            hdg        = START_HEADING;
            depth      = 0;
            fail_count = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_STEP_LENGTH: step_len = value[STEP_W-1:0];
                REG_TURN_ANGLE:  turn = value[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function pos_t axis_shift(int deg);
            int          d;
            bit          neg;
            longint      prod;
            logic [23:0] m;
            d = deg % 360;
            neg = (d >= 180);
            if (neg)
                d = d - 180;
            if (d > 90)
                d = 180 - d;
            prod = longint'(step_len) * QSIN_Q12[d];
            prod = ((prod << FRAC_BITS) + 2048) >>> TRIG_FRAC;
            m = prod[23:0];
            return neg ? pos_t'(-m) : pos_t'(m);
        endfunction

        function void take_command(logic kind, sym_t sym);
            int        t;
            seg_item_t r;
            t = int'(turn) % 360;
            r = '0;
            if (kind == KIND_RESTART) begin
                px = '0;
                py = '0;
                hdg = START_HEADING;
                depth = 0;
                return;
            end
            case (sym)
                SYM_FORWARD: begin
                    r.result_kind = RES_SEGMENT;
                    r.start_x = px;
                    r.start_y = py;
                    px = px + axis_shift(int'(hdg) + 90);
                    py = py + axis_shift(int'(hdg));
                    r.end_x = px;
                    r.end_y = py;
                    pending_segs.push_back(r);
                end
                SYM_TURN_PLUS:  hdg = angle_t'((int'(hdg) + t) % 360);
                SYM_TURN_MINUS: hdg = angle_t'((int'(hdg) + 360 - t) % 360);
                SYM_PUSH: begin
                    if (depth >= STACK_SLOTS) begin
                        r.result_kind = RES_OVERFLOW;
                        pending_segs.push_back(r);
                    end
                    else begin
                        saved_px[depth] = px;
                        saved_py[depth] = py;
                        depth++;
                    end
                end
                SYM_POP: begin
                    if (depth > 0) begin
                        depth--;
                        px = saved_px[depth];
                        py = saved_py[depth];
                    end
                end
                default: ;
            endcase
        endfunction

        function void field_mismatch(string field, int want, int got);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        endfunction

        function void check_segment(seg_item_t got);
            seg_item_t want;
            if (pending_segs.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d (%0d,%0d)-(%0d,%0d)",
                         $time, got.result_kind, got.start_x, got.start_y, got.end_x, got.end_y);
                fail_count++;
                return;
            end
            want = pending_segs.pop_front();
            if (got.result_kind !== want.result_kind)
                field_mismatch("result_kind", want.result_kind, got.result_kind);
            if (got.start_x !== want.start_x)
                field_mismatch("start_x", want.start_x, got.start_x);
            if (got.start_y !== want.start_y)
                field_mismatch("start_y", want.start_y, got.start_y);
            if (got.end_x !== want.end_x)
                field_mismatch("end_x", want.end_x, got.end_x);
            if (got.end_y !== want.end_y)
                field_mismatch("end_y", want.end_y, got.end_y);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tsg_cmd_if cmd_ch ();
    tsg_seg_if seg_ch ();

    segment_predictor predictor;
    cmd_item_t        symbol_q [$];
    int               hold_kick = 0;

    turtle_segment_generator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .seg     (seg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin : monitor
        seg_item_t got;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            predictor.take_command(cmd_ch.kind, cmd_ch.symbol);
        if (rst_n && seg_ch.valid && seg_ch.ready) begin
            got.result_kind = seg_ch.result_kind;
            got.start_x     = seg_ch.start_x;
            got.start_y     = seg_ch.start_y;
            got.end_x       = seg_ch.end_x;
            got.end_y       = seg_ch.end_y;
            predictor.check_segment(got);
        end
    end

    initial
    begin : seg_sink
        int          mode;
        int          mode_left;
        int          hold_left;
        int          kicks_seen;
        logic [31:0] pattern;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        kicks_seen = 0;
        pattern = '1;
        seg_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_kick != kicks_seen) begin
                kicks_seen = hold_kick;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
                pattern = $urandom;
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                seg_ch.ready <= 1'b0;
            end
            else begin
                case (mode)
                    0: seg_ch.ready <= 1'b1;
                    1: seg_ch.ready <= 1'($urandom_range(0, 1));
                    2: seg_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: begin
                        seg_ch.ready <= pattern[0];
                        pattern = {pattern[0], pattern[31:1]};
                    end
                endcase
            end
        end
    end

    function automatic void add_cmd(logic kind, sym_t sym);
        cmd_item_t c;
        c.kind = kind;
        c.symbol = sym;
        symbol_q.push_back(c);
    endfunction

    // cumulative percentages: restart, noise (4), forward, turns, push, then pop
    function automatic void add_random(int count, int rst_pct, int fwd_pct, int turn_pct,
                                       int push_pct);
        int   r;
        int   lim;
        sym_t sym;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            sym = sym_t'($urandom);
            lim = rst_pct;
            if (r < lim) begin
                add_cmd(KIND_RESTART, sym);
                continue;
            end
            lim = lim + 4;
            if (r >= lim) begin
                if (r < lim + fwd_pct)
                    sym = SYM_FORWARD;
                else if (r < lim + fwd_pct + turn_pct / 2)
                    sym = SYM_TURN_PLUS;
                else if (r < lim + fwd_pct + turn_pct)
                    sym = SYM_TURN_MINUS;
                else if (r < lim + fwd_pct + turn_pct + push_pct)
                    sym = SYM_PUSH;
                else
                    sym = SYM_POP;
            end
            add_cmd(KIND_COMMAND, sym);
        end
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] data;
        data = $urandom;
        if (idx == REG_STEP_LENGTH)
            data[STEP_W-1:0] = value[STEP_W-1:0];
        else
            data[ANGLE_W-1:0] = value[ANGLE_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        predictor.set_reg(idx, data);
    endtask

    task automatic set_turtle(step_t step, angle_t angle);
        write_reg(REG_STEP_LENGTH, DATA_W'(step));
        write_reg(REG_TURN_ANGLE, DATA_W'(angle));
    endtask

    task automatic send_commands();
        int burst_left;
        int gap_left;
        burst_left = $urandom_range(1, 24);
        gap_left = 0;
        while (symbol_q.size() != 0) begin
            if (gap_left > 0) begin
                cmd_ch.valid <= 1'b0;
                gap_left--;
                @(posedge clk);
            end
            else begin
                cmd_ch.valid  <= 1'b1;
                cmd_ch.kind   <= symbol_q[0].kind;
                cmd_ch.symbol <= symbol_q[0].symbol;
                @(posedge clk);
                while (!cmd_ch.ready) @(posedge clk);
                void'(symbol_q.pop_front());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        cmd_ch.valid <= 1'b0;
    endtask

    task automatic play_and_drain();
        send_commands();
        @(posedge clk);
        while (predictor.pending_segs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : main_seq
        predictor = new();
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.kind   <= KIND_COMMAND;
        cmd_ch.symbol <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_cmd(KIND_COMMAND, SYM_POP);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        add_cmd(KIND_COMMAND, SYM_TURN_PLUS);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        add_cmd(KIND_COMMAND, SYM_TURN_MINUS);
        add_cmd(KIND_COMMAND, SYM_TURN_MINUS);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        add_cmd(KIND_COMMAND, 8'h00);
        add_cmd(KIND_COMMAND, 8'hFF);
        add_cmd(KIND_COMMAND, SYM_PUSH);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        add_cmd(KIND_COMMAND, SYM_POP);
        add_cmd(KIND_RESTART, SYM_FORWARD);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        play_and_drain();

        set_turtle(8'd255, 9'd359);
        for (int i = 0; i <= STACK_SLOTS; i++)
            add_cmd(KIND_COMMAND, SYM_PUSH);
        add_cmd(KIND_COMMAND, SYM_TURN_PLUS);
        add_cmd(KIND_COMMAND, SYM_FORWARD);
        add_cmd(KIND_COMMAND, SYM_POP);
        play_and_drain();

        // straight run upward so the position wraps
        set_turtle(8'd255, 9'd0);
        add_random(400, 0, 85, 6, 3);
        hold_kick++;
        play_and_drain();

        set_turtle(8'd0, 9'd45);
        add_random(150, 2, 40, 20, 17);
        play_and_drain();

        set_turtle(8'd1, 9'd1);
        add_random(150, 2, 40, 20, 17);
        play_and_drain();

        set_turtle(8'd255, 9'd511);
        add_random(250, 1, 30, 14, 45);
        hold_kick++;
        play_and_drain();

        set_turtle(8'd200, 9'd360);
        add_random(150, 2, 40, 20, 17);
        play_and_drain();

        for (int p = 0; p < 7; p++) begin
            set_turtle(step_t'($urandom_range(0, 255)), angle_t'($urandom_range(0, 511)));
            if (p % 2 == 0)
                add_random(120, 2, 40, 20, 17);
            else
                add_random(120, 1, 30, 14, 45);
            play_and_drain();
        end

        if (predictor.fail_count == 0 && predictor.pending_segs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
